// ===== rtl/core/tcg_pkg.sv =====
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared constants, types and helpers of the texture coordinate generator.
// ----------------------------------------------------------------------------
package tcg_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 40;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_W        = 32 + FRAC_BITS;

    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    localparam logic [3:0] MODE_ENV_INF   = 4'd0;
    localparam logic [3:0] MODE_ENV_LOCAL = 4'd1;
    localparam logic [3:0] MODE_YZ        = 4'd2;
    localparam logic [3:0] MODE_ZX        = 4'd3;
    localparam logic [3:0] MODE_XY        = 4'd4;
    localparam logic [3:0] MODE_AFFINE    = 4'd5;
    localparam logic [3:0] MODE_SCALE     = 4'd6;
    localparam logic [3:0] MODE_SCALE_OFS = 4'd7;
    localparam logic [3:0] MODE_COPY      = 4'd8;
    localparam logic [3:0] MODE_SHIFT     = 4'd9;

    localparam logic [1:0] CFG_MAP_MODE   = 2'd0;
    localparam logic [1:0] CFG_ENV_FRAME  = 2'd1;
    localparam logic [1:0] CFG_U_SHIFT    = 2'd2;
    localparam logic [1:0] CFG_V_SHIFT    = 2'd3;

    localparam logic       OP_LOAD   = 1'b0;
    localparam logic       OP_VERTEX = 1'b1;

    localparam logic [4:0] COEF_EYE  = 5'd6;
    localparam logic [4:0] COEF_ROT  = 5'd9;
    localparam logic [4:0] NUM_COEF  = 5'd18;

    typedef struct packed {
        logic             op;
        logic [4:0]       idx;
        logic [31:0]      val;
        logic [2:0][31:0] p;
        logic [1:0][31:0] m;
    } carry_t;

    typedef struct packed {
        carry_t           c;
        logic [2:0][31:0] n;
        logic [2:0][31:0] e;
    } side1_t;

    typedef struct packed {
        carry_t           c;
        logic [2:0][31:0] r;
    } side2_t;

    typedef struct packed {
        carry_t      c;
        logic        zero;
        logic [31:0] sv;
    } cside_t;

    function automatic logic [63:0] smul(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] ea;
        logic signed [63:0] eb;
        ea = 64'($signed(a));
        eb = 64'($signed(b));
        return 64'(ea * eb);
    endfunction

    function automatic logic [31:0] fx(input logic [63:0] acc);
        return acc[FRAC_BITS+31:FRAC_BITS];
    endfunction

endpackage

// ===== rtl/core/tcg_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tcg_sqrt_cell
// One root bit of a restoring integer square root, registered.
// ----------------------------------------------------------------------------
module tcg_sqrt_cell #(
    parameter int PW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vld_i,
    input  logic [63:0]   rad_i,
    input  logic [33:0]   rem_i,
    input  logic [31:0]   root_i,
    input  logic [PW-1:0] pass_i,
    output logic          vld_o,
    output logic [63:0]   rad_o,
    output logic [33:0]   rem_o,
    output logic [31:0]   root_o,
    output logic [PW-1:0] pass_o
);
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;
    logic [35:0] rem_dif;

    assign rem_sh  = {rem_i, rad_i[63:62]};
    assign trial   = {2'b00, root_i, 2'b01};
    assign ge      = (rem_sh >= trial);
    assign rem_dif = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_o <= 1'b0;
        end
        else if (en)
        begin
            vld_o <= vld_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_o  <= {rad_i[61:0], 2'b00};
            rem_o  <= ge ? rem_dif[33:0] : rem_sh[33:0];
            root_o <= {root_i[30:0], ge};
            pass_o <= pass_i;
        end
    end

endmodule

// ===== rtl/core/tcg_div_cell.sv =====
// ----------------------------------------------------------------------------
// tcg_div_cell
// One quotient bit of a three-lane restoring divide by a shared divisor.
// ----------------------------------------------------------------------------
module tcg_div_cell #(
    parameter int PW = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        vld_i,
    input  logic [31:0]                 dvs_i,
    input  logic [2:0][tcg_pkg::DIV_W-1:0] work_i,
    input  logic [2:0][31:0]            rem_i,
    input  logic [PW-1:0]               pass_i,
    output logic                        vld_o,
    output logic [31:0]                 dvs_o,
    output logic [2:0][tcg_pkg::DIV_W-1:0] work_o,
    output logic [2:0][31:0]            rem_o,
    output logic [PW-1:0]               pass_o
);
    import tcg_pkg::*;

    logic [2:0][32:0] t;
    logic [2:0][32:0] t_dif;
    logic [2:0]       ge;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t[k]     = {rem_i[k], work_i[k][DIV_W-1]};
            ge[k]    = (t[k] >= {1'b0, dvs_i});
            t_dif[k] = t[k] - {1'b0, dvs_i};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_o <= 1'b0;
        end
        else if (en)
        begin
            vld_o <= vld_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvs_o  <= dvs_i;
            pass_o <= pass_i;
            for (int k = 0; k < 3; k++)
            begin
                work_o[k] <= {work_i[k][DIV_W-2:0], ge[k]};
                rem_o[k]  <= ge[k] ? t_dif[k][31:0] : t[k][31:0];
            end
        end
    end

endmodule

// ===== rtl/core/tcg_norm.sv =====
// ----------------------------------------------------------------------------
// tcg_norm
// Pipelined vector normalize: squares, sum, root cells, divide cells.
// ----------------------------------------------------------------------------
module tcg_norm #(
    parameter int SW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_i,
    input  logic [2:0][31:0] vec_i,
    input  logic [SW-1:0]    side_i,
    output logic             vld_o,
    output logic [2:0][31:0] vec_o,
    output logic [SW-1:0]    side_o
);
    import tcg_pkg::*;

    localparam int PS = SW + 3 + 96;
    localparam int PD = SW + 4;

    logic             vld_q_reg;
    logic [2:0][63:0] sq_q_reg;
    logic [2:0]       sgn_q_reg;
    logic [2:0][31:0] mag_q_reg;
    logic [SW-1:0]    side_q_reg;

    logic             vld_s_reg;
    logic [63:0]      sum_s_reg;
    logic [PS-1:0]    pass_s_reg;

    logic          sq_vld  [0:SQRT_STEPS];
    logic [63:0]   sq_rad  [0:SQRT_STEPS];
    logic [33:0]   sq_rem  [0:SQRT_STEPS];
    logic [31:0]   sq_root [0:SQRT_STEPS];
    logic [PS-1:0] sq_pass [0:SQRT_STEPS];

    logic                   dv_vld  [0:DIV_W];
    logic [31:0]            dv_dvs  [0:DIV_W];
    logic [2:0][DIV_W-1:0]  dv_work [0:DIV_W];
    logic [2:0][31:0]       dv_rem  [0:DIV_W];
    logic [PD-1:0]          dv_pass [0:DIV_W];

    logic [2:0][31:0] sq_mag;
    logic [2:0]       sq_sgn;
    logic [SW-1:0]    sq_side;
    logic [2:0]       fin_sgn;
    logic             fin_zero;
    logic [2:0][31:0] fin_vec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_q_reg <= 1'b0;
            vld_s_reg <= 1'b0;
            vld_o     <= 1'b0;
        end
        else if (en)
        begin
            vld_q_reg <= vld_i;
            vld_s_reg <= vld_q_reg;
            vld_o     <= dv_vld[DIV_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_q_reg[k]  <= smul(vec_i[k], vec_i[k]);
                sgn_q_reg[k] <= vec_i[k][31];
                mag_q_reg[k] <= vec_i[k][31] ? (32'd0 - vec_i[k]) : vec_i[k];
            end
            side_q_reg <= side_i;
            sum_s_reg  <= sq_q_reg[0] + sq_q_reg[1] + sq_q_reg[2];
            pass_s_reg <= {side_q_reg, sgn_q_reg, mag_q_reg};
            side_o     <= dv_pass[DIV_W][PD-1:4];
            vec_o      <= fin_vec;
        end
    end

    assign sq_vld[0]  = vld_s_reg;
    assign sq_rad[0]  = sum_s_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_pass[0] = pass_s_reg;

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        tcg_sqrt_cell #(.PW(PS)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .vld_i  (sq_vld[i]),
            .rad_i  (sq_rad[i]),
            .rem_i  (sq_rem[i]),
            .root_i (sq_root[i]),
            .pass_i (sq_pass[i]),
            .vld_o  (sq_vld[i+1]),
            .rad_o  (sq_rad[i+1]),
            .rem_o  (sq_rem[i+1]),
            .root_o (sq_root[i+1]),
            .pass_o (sq_pass[i+1])
        );
    end

    assign sq_mag  = sq_pass[SQRT_STEPS][95:0];
    assign sq_sgn  = sq_pass[SQRT_STEPS][98:96];
    assign sq_side = sq_pass[SQRT_STEPS][PS-1:99];

    assign dv_vld[0]  = sq_vld[SQRT_STEPS];
    assign dv_dvs[0]  = sq_root[SQRT_STEPS];
    assign dv_rem[0]  = '0;
    assign dv_pass[0] = {sq_side, (sq_root[SQRT_STEPS] == 32'd0), sq_sgn};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dv_work[0][k] = {sq_mag[k], {FRAC_BITS{1'b0}}};
        end
    end

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_div
        tcg_div_cell #(.PW(PD)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .vld_i  (dv_vld[i]),
            .dvs_i  (dv_dvs[i]),
            .work_i (dv_work[i]),
            .rem_i  (dv_rem[i]),
            .pass_i (dv_pass[i]),
            .vld_o  (dv_vld[i+1]),
            .dvs_o  (dv_dvs[i+1]),
            .work_o (dv_work[i+1]),
            .rem_o  (dv_rem[i+1]),
            .pass_o (dv_pass[i+1])
        );
    end

    assign fin_sgn  = dv_pass[DIV_W][2:0];
    assign fin_zero = dv_pass[DIV_W][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (fin_zero)
            begin
                fin_vec[k] = (k == 0) ? (32'd1 << FRAC_BITS) : 32'd0;
            end
            else if (fin_sgn[k])
            begin
                fin_vec[k] = 32'd0 - dv_work[DIV_W][k][31:0];
            end
            else
            begin
                fin_vec[k] = dv_work[DIV_W][k][31:0];
            end
        end
    end

endmodule

// ===== rtl/core/tcg_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tcg_cordic_cell
// One vectoring micro-rotation of the angle chain, registered.
// ----------------------------------------------------------------------------
module tcg_cordic_cell #(
    parameter int PW   = 1,
    parameter int STEP = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                vld_i,
    input  logic signed [tcg_pkg::CORDIC_W-1:0] a_i,
    input  logic signed [tcg_pkg::CORDIC_W-1:0] b_i,
    input  logic [31:0]                         acc_i,
    input  logic [PW-1:0]                       pass_i,
    output logic                                vld_o,
    output logic signed [tcg_pkg::CORDIC_W-1:0] a_o,
    output logic signed [tcg_pkg::CORDIC_W-1:0] b_o,
    output logic [31:0]                         acc_o,
    output logic [PW-1:0]                       pass_o
);
    import tcg_pkg::*;

    logic signed [CORDIC_W-1:0] a_sh;
    logic signed [CORDIC_W-1:0] b_sh;

    assign a_sh = a_i >>> STEP;
    assign b_sh = b_i >>> STEP;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_o <= 1'b0;
        end
        else if (en)
        begin
            vld_o <= vld_i;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pass_o <= pass_i;
            if (!b_i[CORDIC_W-1])
            begin
                a_o   <= a_i + b_sh;
                b_o   <= b_i - a_sh;
                acc_o <= acc_i + ATAN_TURNS[STEP];
            end
            else
            begin
                a_o   <= a_i - b_sh;
                b_o   <= b_i + a_sh;
                acc_o <= acc_i - ATAN_TURNS[STEP];
            end
        end
    end

endmodule

// ===== rtl/core/texture_coordinate_generator.sv =====
// ----------------------------------------------------------------------------
// texture_coordinate_generator
// Per-vertex texture coordinate generator, signed 16.16 fixed point.
// ----------------------------------------------------------------------------
// Input channel (vtx_valid / vtx_stall): op selects a coefficient load or a
// vertex. Loads produce no item on the output; vertices produce one
// (tex_u, tex_v) item on the tex_valid / tex_stall channel, in order.
// Configuration (mode, frame enable, shifts) goes through the APB port; the
// user must write it only while the block is idle, which the block itself
// does not enforce; pready is always high. Every item walks the same
// pipeline of cells: the input register, eye normalize (2 square/sum
// stages, 32 root cells, 48 divide cells, 1 output stage), reflection
// (4 stages), rotation (2), frame normalize (83), angle prep (1), 24 angle
// cells, map multiply (1) and the output register. One item is accepted per
// clock while the output is not stalled. When the output item is stalled
// the whole pipeline holds and vtx_stall is raised; otherwise an item can be
// taken in every cycle. Reset empties the pipeline and sets the mode to the
// affine map; the coefficient table is undefined until loaded.
// ----------------------------------------------------------------------------
module texture_coordinate_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               vtx_valid,
    output logic               vtx_stall,
    input  logic               op,
    input  logic [4:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] map_u,
    input  logic signed [31:0] map_v,
    input  logic signed [31:0] norm_x,
    input  logic signed [31:0] norm_y,
    input  logic signed [31:0] norm_z,
    output logic               tex_valid,
    input  logic               tex_stall,
    output logic signed [31:0] tex_u,
    output logic signed [31:0] tex_v,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tcg_pkg::*;

    localparam int SW1 = $bits(side1_t);
    localparam int SW2 = $bits(side2_t);
    localparam int SWC = $bits(cside_t);
    localparam int SHL = (FRAC_BITS >= ANGLE_BITS) ? (FRAC_BITS - ANGLE_BITS) : 0;
    localparam int SHR = (FRAC_BITS >= ANGLE_BITS) ? 0 : (ANGLE_BITS - FRAC_BITS);

    logic [3:0] map_mode_reg;
    logic       env_frame_reg;
    logic [3:0] u_shift_reg;
    logic [3:0] v_shift_reg;

    logic [31:0] eye_reg [0:2];
    logic [31:0] rot_reg [0:8];
    logic [31:0] mat_reg [0:5];

    logic adv;
    logic accept;
    logic cfg_wr;

    // input stage
    logic             vld0_reg;
    carry_t           c0_reg;
    logic [2:0][31:0] n0_reg;
    logic [2:0][31:0] e0;
    logic [2:0][31:0] eye_v;
    logic [4:0]       eye_sel;
    side1_t           side1_in;
    side1_t           side1_out;
    logic [SW1-1:0]   side1_out_bits;
    logic             vld1;
    logic [2:0][31:0] en1;

    // reflection
    logic             vld_d1_reg;
    carry_t           c_d1_reg;
    logic [2:0][31:0] n_d1_reg;
    logic [2:0][31:0] e_d1_reg;
    logic [2:0][63:0] pr_d1_reg;
    logic [63:0]      dot_sum;
    logic             vld_d2_reg;
    carry_t           c_d2_reg;
    logic [2:0][31:0] n_d2_reg;
    logic [2:0][31:0] e_d2_reg;
    logic [31:0]      d_d2_reg;
    logic [31:0]      dot_fx;
    logic             vld_r1_reg;
    carry_t           c_r1_reg;
    logic [2:0][31:0] e_r1_reg;
    logic [2:0][63:0] pr_r1_reg;
    logic             vld_r2_reg;
    carry_t           c_r2_reg;
    logic [2:0][31:0] r_r2_reg;
    logic [4:0]       rot_sel;

    // rotation
    logic             vld_m1_reg;
    carry_t           c_t1_reg;
    logic [2:0][31:0] r_t1_reg;
    logic [2:0][2:0][63:0] pr_t1_reg;
    logic             vld_t2_reg;
    carry_t           c_t2_reg;
    logic [2:0][31:0] r_t2_reg;
    logic [2:0][31:0] w_t2_reg;
    side2_t           side2_in;
    side2_t           side2_out;
    logic [SW2-1:0]   side2_out_bits;
    logic             vld2;
    logic [2:0][31:0] en2;
    logic [2:0][31:0] wf;

    // angle
    logic                       vld_cp_reg;
    logic signed [CORDIC_W-1:0] a_cp_reg;
    logic signed [CORDIC_W-1:0] b_cp_reg;
    logic [31:0]                acc_cp_reg;
    cside_t                     cs_cp_reg;
    logic signed [CORDIC_W-1:0] a_pre;
    logic signed [CORDIC_W-1:0] b_pre;
    logic signed [32:0]         negy;
    logic signed [32:0]         halfy;

    logic                       cd_vld  [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cd_a    [0:CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cd_b    [0:CORDIC_STEPS];
    logic [31:0]                cd_acc  [0:CORDIC_STEPS];
    logic [SWC-1:0]             cd_pass [0:CORDIC_STEPS];

    cside_t                cs_end;
    logic [32:0]           ang_sum;
    logic [31:0]           ang32;
    logic [31:0]           su_env;
    logic [31:0]           su_sel;
    logic [31:0]           sv_sel;
    logic [4:0]            mat_sel;

    // map
    logic        vld_p1_reg;
    logic        op_p1_reg;
    logic [63:0] pa_p1_reg;
    logic [63:0] pb_p1_reg;
    logic [63:0] pc_p1_reg;
    logic [63:0] pd_p1_reg;
    logic [31:0] t4_p1_reg;
    logic [31:0] t5_p1_reg;
    logic [31:0] mu_p1_reg;
    logic [31:0] mv_p1_reg;
    logic [31:0] tu_next;
    logic [31:0] tv_next;

    logic        tex_valid_reg;
    logic [31:0] tex_u_reg;
    logic [31:0] tex_v_reg;

    // ---------------- handshake and configuration ----------------
    assign adv       = !(tex_valid_reg && tex_stall);
    assign vtx_stall = !adv;
    assign accept    = vtx_valid && adv;
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_mode_reg  <= MODE_AFFINE;
            env_frame_reg <= 1'b0;
            u_shift_reg   <= 4'd0;
            v_shift_reg   <= 4'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                CFG_MAP_MODE:  map_mode_reg  <= pwdata[3:0];
                CFG_ENV_FRAME: env_frame_reg <= pwdata[0];
                CFG_U_SHIFT:   u_shift_reg   <= pwdata[3:0];
                CFG_V_SHIFT:   v_shift_reg   <= pwdata[3:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            CFG_MAP_MODE:  prdata = {28'd0, map_mode_reg};
            CFG_ENV_FRAME: prdata = {31'd0, env_frame_reg};
            CFG_U_SHIFT:   prdata = {28'd0, u_shift_reg};
            CFG_V_SHIFT:   prdata = {28'd0, v_shift_reg};
        endcase
    end

    // ---------------- control registers of the pipe ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg      <= 1'b0;
            vld_d1_reg    <= 1'b0;
            vld_d2_reg    <= 1'b0;
            vld_r1_reg    <= 1'b0;
            vld_r2_reg    <= 1'b0;
            vld_m1_reg    <= 1'b0;
            vld_t2_reg    <= 1'b0;
            vld_cp_reg    <= 1'b0;
            vld_p1_reg    <= 1'b0;
            tex_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld0_reg      <= vtx_valid;
            vld_d1_reg    <= vld1;
            vld_d2_reg    <= vld_d1_reg;
            vld_r1_reg    <= vld_d2_reg;
            vld_r2_reg    <= vld_r1_reg;
            vld_m1_reg    <= vld_r2_reg;
            vld_t2_reg    <= vld_m1_reg;
            vld_cp_reg    <= vld2;
            vld_p1_reg    <= cd_vld[CORDIC_STEPS];
            tex_valid_reg <= vld_p1_reg && (op_p1_reg == OP_VERTEX);
        end
    end

    // ---------------- coefficient copies, each written where it is read ----------------
    assign eye_sel = coef_index - COEF_EYE;
    assign rot_sel = c_r2_reg.idx - COEF_ROT;
    assign mat_sel = cs_end.c.idx;

    always_ff @(posedge clk)
    begin
        if (accept && (op == OP_LOAD) && (coef_index >= COEF_EYE)
            && (coef_index < COEF_ROT))
        begin
            eye_reg[eye_sel[1:0]] <= coef_value;
        end
        if (adv && vld_r2_reg && (c_r2_reg.op == OP_LOAD)
            && (c_r2_reg.idx >= COEF_ROT) && (c_r2_reg.idx < NUM_COEF))
        begin
            rot_reg[rot_sel[3:0]] <= c_r2_reg.val;
        end
        if (adv && cd_vld[CORDIC_STEPS] && (cs_end.c.op == OP_LOAD)
            && (cs_end.c.idx < COEF_EYE))
        begin
            mat_reg[mat_sel[2:0]] <= cs_end.c.val;
        end
    end

    // ---------------- input stage and eye vector ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c0_reg.op  <= op;
            c0_reg.idx <= coef_index;
            c0_reg.val <= coef_value;
            c0_reg.p   <= {pos_z, pos_y, pos_x};
            c0_reg.m   <= {map_v, map_u};
            n0_reg     <= {norm_z, norm_y, norm_x};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            eye_v[k] = eye_reg[k];
            e0[k]    = (map_mode_reg == MODE_ENV_LOCAL) ? (eye_reg[k] - c0_reg.p[k])
                                                         : eye_reg[k];
        end
    end

    assign side1_in.c = c0_reg;
    assign side1_in.n = n0_reg;
    assign side1_in.e = eye_v;

    tcg_norm #(.SW(SW1)) u_norm_eye (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .vld_i  (vld0_reg),
        .vec_i  (e0),
        .side_i (side1_in),
        .vld_o  (vld1),
        .vec_o  (en1),
        .side_o (side1_out_bits)
    );

    assign side1_out = side1_t'(side1_out_bits);

    // ---------------- reflection R = 2N(N.E) - E ----------------
    assign dot_sum = pr_d1_reg[0] + pr_d1_reg[1] + pr_d1_reg[2];
    assign dot_fx  = fx(dot_sum);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_d1_reg <= side1_out.c;
            n_d1_reg <= side1_out.n;
            for (int k = 0; k < 3; k++)
            begin
                e_d1_reg[k]  <= (map_mode_reg == MODE_ENV_LOCAL) ? en1[k] : side1_out.e[k];
                pr_d1_reg[k] <= smul((map_mode_reg == MODE_ENV_LOCAL) ? en1[k]
                                                                      : side1_out.e[k],
                                     side1_out.n[k]);
            end

            c_d2_reg <= c_d1_reg;
            n_d2_reg <= n_d1_reg;
            e_d2_reg <= e_d1_reg;
            d_d2_reg <= {dot_fx[30:0], 1'b0};

            c_r1_reg <= c_d2_reg;
            e_r1_reg <= e_d2_reg;
            for (int k = 0; k < 3; k++)
            begin
                pr_r1_reg[k] <= smul(n_d2_reg[k], d_d2_reg);
            end

            c_r2_reg <= c_r1_reg;
            for (int k = 0; k < 3; k++)
            begin
                r_r2_reg[k] <= fx(pr_r1_reg[k]) - e_r1_reg[k];
            end

            c_t1_reg <= c_r2_reg;
            r_t1_reg <= r_r2_reg;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    pr_t1_reg[i][j] <= smul(r_r2_reg[i], rot_reg[3*i+j]);
                end
            end

            c_t2_reg <= c_t1_reg;
            r_t2_reg <= r_t1_reg;
            for (int j = 0; j < 3; j++)
            begin
                w_t2_reg[j] <= fx(pr_t1_reg[0][j] + pr_t1_reg[1][j] + pr_t1_reg[2][j]);
            end
        end
    end

    assign side2_in.c = c_t2_reg;
    assign side2_in.r = r_t2_reg;

    tcg_norm #(.SW(SW2)) u_norm_frame (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .vld_i  (vld_t2_reg),
        .vec_i  (w_t2_reg),
        .side_i (side2_in),
        .vld_o  (vld2),
        .vec_o  (en2),
        .side_o (side2_out_bits)
    );

    assign side2_out = side2_t'(side2_out_bits);
    assign wf        = env_frame_reg ? en2 : side2_out.r;

    // ---------------- angle preparation and cells ----------------
    assign a_pre = CORDIC_W'(-$signed({wf[2][31], wf[2]}));
    assign b_pre = CORDIC_W'($signed(wf[0]));
    assign negy  = -$signed({wf[1][31], wf[1]});
    assign halfy = (negy + $signed({32'd0, negy[32]})) >>> 1;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cs_cp_reg.c    <= side2_out.c;
            cs_cp_reg.zero <= (a_pre == '0) && (b_pre == '0);
            cs_cp_reg.sv   <= (32'd1 << (FRAC_BITS - 1)) + halfy[31:0];
            if (a_pre[CORDIC_W-1])
            begin
                a_cp_reg   <= -a_pre;
                b_cp_reg   <= -b_pre;
                acc_cp_reg <= 32'h8000_0000;
            end
            else
            begin
                a_cp_reg   <= a_pre;
                b_cp_reg   <= b_pre;
                acc_cp_reg <= 32'd0;
            end
        end
    end

    assign cd_vld[0]  = vld_cp_reg;
    assign cd_a[0]    = a_cp_reg;
    assign cd_b[0]    = b_cp_reg;
    assign cd_acc[0]  = acc_cp_reg;
    assign cd_pass[0] = cs_cp_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        tcg_cordic_cell #(.PW(SWC), .STEP(i)) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (adv),
            .vld_i  (cd_vld[i]),
            .a_i    (cd_a[i]),
            .b_i    (cd_b[i]),
            .acc_i  (cd_acc[i]),
            .pass_i (cd_pass[i]),
            .vld_o  (cd_vld[i+1]),
            .a_o    (cd_a[i+1]),
            .b_o    (cd_b[i+1]),
            .acc_o  (cd_acc[i+1]),
            .pass_o (cd_pass[i+1])
        );
    end

    assign cs_end  = cside_t'(cd_pass[CORDIC_STEPS]);
    assign ang_sum = {1'b0, cd_acc[CORDIC_STEPS]} + (33'd1 << (31 - ANGLE_BITS));
    assign ang32   = 32'(ang_sum[31:32-ANGLE_BITS]);
    assign su_env  = cs_end.zero ? 32'd0 : ((ang32 << SHL) >> SHR);

    always_comb
    begin
        unique case (map_mode_reg)
            MODE_ENV_INF, MODE_ENV_LOCAL:
            begin
                su_sel = su_env;
                sv_sel = cs_end.sv;
            end
            MODE_YZ:
            begin
                su_sel = cs_end.c.p[1];
                sv_sel = cs_end.c.p[2];
            end
            MODE_ZX:
            begin
                su_sel = cs_end.c.p[2];
                sv_sel = cs_end.c.p[0];
            end
            MODE_XY:
            begin
                su_sel = cs_end.c.p[0];
                sv_sel = cs_end.c.p[1];
            end
            default:
            begin
                su_sel = cs_end.c.m[0];
                sv_sel = cs_end.c.m[1];
            end
        endcase
    end

    // ---------------- map transform ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_p1_reg <= cs_end.c.op;
            pa_p1_reg <= smul(mat_reg[0], su_sel);
            pb_p1_reg <= smul(mat_reg[2], sv_sel);
            pc_p1_reg <= smul(mat_reg[1], su_sel);
            pd_p1_reg <= smul(mat_reg[3], sv_sel);
            t4_p1_reg <= mat_reg[4];
            t5_p1_reg <= mat_reg[5];
            mu_p1_reg <= cs_end.c.m[0];
            mv_p1_reg <= cs_end.c.m[1];
        end
    end

    always_comb
    begin
        unique case (map_mode_reg)
            MODE_SCALE:
            begin
                tu_next = fx(pa_p1_reg);
                tv_next = fx(pd_p1_reg);
            end
            MODE_SCALE_OFS:
            begin
                tu_next = fx(pa_p1_reg) + t4_p1_reg;
                tv_next = fx(pd_p1_reg) + t5_p1_reg;
            end
            MODE_COPY:
            begin
                tu_next = mu_p1_reg;
                tv_next = mv_p1_reg;
            end
            MODE_SHIFT:
            begin
                tu_next = (mu_p1_reg << u_shift_reg) + t4_p1_reg;
                tv_next = (mv_p1_reg << v_shift_reg) + t5_p1_reg;
            end
            default:
            begin
                tu_next = fx(pa_p1_reg + pb_p1_reg) + t4_p1_reg;
                tv_next = fx(pc_p1_reg + pd_p1_reg) + t5_p1_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tex_u_reg <= tu_next;
            tex_v_reg <= tv_next;
        end
    end

    assign tex_valid = tex_valid_reg;
    assign tex_u     = tex_u_reg;
    assign tex_v     = tex_v_reg;

    // ---------------- checks ----------------
    a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_p1_reg && (op_p1_reg == OP_LOAD)) |=> !tex_valid)
        else $error("load item reached the output");

    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(vld_cp_reg) && $stable(vld_p1_reg)))
        else $error("pipeline moved while output held");

    a_copy_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_p1_reg && (op_p1_reg == OP_VERTEX) && (map_mode_reg == MODE_COPY)
         && !cfg_wr)
        |=> (tex_u == $past(mu_p1_reg)) && (tex_v == $past(mv_p1_reg)))
        else $error("copy mode output differs from map coordinates");

endmodule
